>>> rtl/fwdf_pkg.sv
package fwdf_pkg;

    localparam logic [31:0] C_MAX_VALUE  = 32'd9999;
    localparam int          C_REM_W      = 14;
    localparam int          C_DIV_STEPS  = 12;   // 3 digits x 4 quotient bits

    localparam logic [7:0] C_CH_STAR  = 8'h2A;
    localparam logic [7:0] C_CH_SPACE = 8'h20;
    localparam logic [7:0] C_CH_POINT = 8'h2E;
    localparam logic [7:0] C_CH_C     = 8'h63;
    localparam logic [7:0] C_CH_M     = 8'h6D;
    localparam logic [7:0] C_CH_ZERO  = 8'h30;

    localparam logic C_ACT_PLAIN    = 1'b0;
    localparam logic C_ACT_DISTANCE = 1'b1;

    // Decimal weight of the digit being extracted: thousands, hundreds, tens.
    function automatic logic [C_REM_W-1:0] f_weight(input logic [1:0] pos);
        logic [C_REM_W-1:0] w;
        unique case (pos)
            2'd0:    w = C_REM_W'(1000);
            2'd1:    w = C_REM_W'(100);
            2'd2:    w = C_REM_W'(10);
            default: w = C_REM_W'(1);
        endcase
        return w;
    endfunction

    function automatic logic [7:0] f_digit_char(input logic over, input logic [3:0] d);
        logic [7:0] c;
        if (over) begin
            c = C_CH_STAR;
        end else begin
            c = C_CH_ZERO + {4'd0, d};
        end
        return c;
    endfunction

endpackage

>>> rtl/fixed_width_decimal_formatter.sv
// Channel | valid   | ready   | payload
// --------+---------+---------+------------------------
// input   | i_valid | o_ready | i_action, i_value
// output  | o_valid | i_ready | o_char_out, o_last
//
// An item is accepted, then divided in the shared compare-subtract unit
// (4 quotient bits each for thousands, hundreds, tens; ones is the remainder),
// and sent as 5 (plain) or 8 (distance) characters, one per cycle unless stalled.
// o_ready is high only while no item is in work; the next item can be taken
// while the final character still sits in the output register.
// Output stalls hold the character sequencer. i_rst_n is synchronous, active low.
module fixed_width_decimal_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_char_out,
    output logic        o_last
);

    localparam int REM_W = fwdf_pkg::C_REM_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

    t_state             r_state;
    logic [3:0]         r_step;
    logic [REM_W-1:0]   r_rem;
    logic               r_over;
    logic               r_act;
    logic [3:0]         r_dig0;
    logic [3:0]         r_dig1;
    logic [3:0]         r_dig2;
    logic [3:0]         r_dig3;
    logic [2:0]         r_idx;
    logic               r_out_valid;
    logic [7:0]         r_char;
    logic               r_last;

    logic               w_in_acc;
    logic [1:0]         w_pos;
    logic [1:0]         w_bit;
    logic [REM_W-1:0]   w_sub;
    logic [REM_W:0]     w_trial;
    logic               w_take;
    logic [REM_W-1:0]   n_rem;
    logic               w_load;
    logic               w_blank0;
    logic               w_blank1;
    logic               w_blank2;
    logic [7:0]         n_char;
    logic               n_last;

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_char_out = r_char;
    assign o_last     = r_last;

    assign w_in_acc = i_valid && o_ready;

    // Shared restoring divide step: step counter gives digit and quotient bit.
    assign w_pos   = r_step[3:2];
    assign w_bit   = ~r_step[1:0];
    assign w_sub   = fwdf_pkg::f_weight(w_pos) << w_bit;
    assign w_trial = {1'b0, r_rem} - {1'b0, w_sub};
    assign w_take  = !w_trial[REM_W];
    assign n_rem   = w_take ? w_trial[REM_W-1:0] : r_rem;

    assign w_load = (r_state == S_EMIT) && (!r_out_valid || i_ready);

    // Leading-zero blanking, plain format only; ones digit always shown.
    assign w_blank0 = (r_act == fwdf_pkg::C_ACT_PLAIN) && !r_over && (r_dig0 == 4'd0);
    assign w_blank1 = w_blank0 && (r_dig1 == 4'd0);
    assign w_blank2 = w_blank1 && (r_dig2 == 4'd0);

    always_comb begin
        n_char = fwdf_pkg::C_CH_SPACE;
        n_last = 1'b0;
        if (r_act == fwdf_pkg::C_ACT_PLAIN) begin
            unique case (r_idx)
                3'd0: n_char = w_blank0 ? fwdf_pkg::C_CH_SPACE
                                        : fwdf_pkg::f_digit_char(r_over, r_dig0);
                3'd1: n_char = w_blank1 ? fwdf_pkg::C_CH_SPACE
                                        : fwdf_pkg::f_digit_char(r_over, r_dig1);
                3'd2: n_char = w_blank2 ? fwdf_pkg::C_CH_SPACE
                                        : fwdf_pkg::f_digit_char(r_over, r_dig2);
                3'd3: n_char = fwdf_pkg::f_digit_char(r_over, r_dig3);
                default: begin
                    n_char = fwdf_pkg::C_CH_SPACE;
                    n_last = 1'b1;
                end
            endcase
        end else begin
            unique case (r_idx)
                3'd0: n_char = fwdf_pkg::f_digit_char(r_over, r_dig0);
                3'd1: n_char = fwdf_pkg::C_CH_POINT;
                3'd2: n_char = fwdf_pkg::f_digit_char(r_over, r_dig1);
                3'd3: n_char = fwdf_pkg::f_digit_char(r_over, r_dig2);
                3'd4: n_char = fwdf_pkg::f_digit_char(r_over, r_dig3);
                3'd5: n_char = fwdf_pkg::C_CH_SPACE;
                3'd6: n_char = fwdf_pkg::C_CH_C;
                default: begin
                    n_char = fwdf_pkg::C_CH_M;
                    n_last = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= 4'd0;
            r_idx       <= 3'd0;
        end else begin
            if (r_out_valid && i_ready && !w_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_act   <= i_action;
                        r_over  <= (i_value > fwdf_pkg::C_MAX_VALUE);
                        // over-range values divide zero; digits are starred anyway
                        r_rem   <= (i_value > fwdf_pkg::C_MAX_VALUE) ? '0
                                                                     : i_value[REM_W-1:0];
                        r_step  <= 4'd0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    unique case (w_pos)
                        2'd0:    r_dig0[w_bit] <= w_take;
                        2'd1:    r_dig1[w_bit] <= w_take;
                        default: r_dig2[w_bit] <= w_take;
                    endcase
                    if (r_step == 4'(fwdf_pkg::C_DIV_STEPS - 1)) begin
                        r_dig3  <= n_rem[3:0];
                        r_idx   <= 3'd0;
                        r_state <= S_EMIT;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                default: begin
                    if (w_load) begin
                        r_char      <= n_char;
                        r_last      <= n_last;
                        r_out_valid <= 1'b1;
                        r_idx       <= r_idx + 3'd1;
                        if (n_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // restoring division invariant: remainder below twice the trial subtrahend
    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ({1'b0, r_rem} < ({1'b0, w_sub} << 1)))
        else $error("remainder out of range during divide");

    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_DIV) && (r_step == 4'd0))
        else $error("accepted item did not start divide");

    a_div_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_step < 4'(fwdf_pkg::C_DIV_STEPS)))
        else $error("divide step counter overran");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && n_last) |=> o_valid && o_last && (r_state == S_IDLE))
        else $error("final character did not end the item");

    a_emit_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_act == fwdf_pkg::C_ACT_PLAIN) |-> (r_idx <= 3'd4))
        else $error("plain format index overran");
`endif

endmodule
